// ===== rtl/core/tsc_pkg.sv =====
`default_nettype none

package tsc_pkg;

  // byte store geometry
  localparam int unsigned STORE_BYTES = 21;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);

  // ASCII codes
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // payload lengths
  localparam logic [7:0] LEN_PREFIX = 8'd2;
  localparam logic [7:0] LEN_BIN_S  = 8'd3;
  localparam logic [7:0] LEN_BIN_L  = 8'd7;
  localparam logic [7:0] LEN_TXT_S  = 8'd8;
  localparam logic [7:0] LEN_TXT_L  = 8'd19;
  localparam logic [7:0] LEN_SCHED  = 8'd19;
  localparam logic [7:0] CNT_MAX    = 8'd255;

  // ranges
  localparam logic [7:0]  HOUR_MAX   = 8'd23;
  localparam logic [7:0]  MIN_MAX    = 8'd59;
  localparam logic [7:0]  DAY_MAX    = 8'd31;
  localparam logic [7:0]  MON_MAX    = 8'd12;
  localparam logic [15:0] YEAR_LO    = 16'd2000;
  localparam logic [15:0] YEAR_HI    = 16'd2099;
  localparam logic [6:0]  CENTURY    = 7'd20;
  localparam logic [6:0]  SHORT_YEAR = 7'd26;
  localparam logic [10:0] MIN_PER_H  = 11'd60;

  // schedule after reset: 14:00, 19:00, 23:00
  localparam logic [10:0] FEED0_RST = 11'd840;
  localparam logic [10:0] FEED1_RST = 11'd1140;
  localparam logic [10:0] FEED2_RST = 11'd1380;

  typedef enum logic [1:0] {
    OC_TIME_OK   = 2'd0,
    OC_SCHED_OK  = 2'd1,
    OC_TIME_BAD  = 2'd2,
    OC_SCHED_BAD = 2'd3
  } outcome_e;

  typedef logic [2:0][10:0] sched_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [4:0]  hours;
    logic [5:0]  minutes_out;
    logic [5:0]  seconds_out;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [6:0]  year_offset;
    sched_t      feed;
  } res_t;

  typedef struct packed {
    logic   wr;
    sched_t times;
  } sched_upd_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] val;
  } dig2_t;

  typedef struct packed {
    logic        ok;
    logic [10:0] mins;
  } hhmm_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // two ASCII digits -> 0..99
  function automatic dig2_t dig2(input logic [7:0] hi, input logic [7:0] lo);
    dig2_t      r;
    logic [7:0] dh;
    logic [7:0] dl;
    dh    = hi - CH_ZERO;
    dl    = lo - CH_ZERO;
    r.ok  = is_dig(hi) && is_dig(lo);
    r.val = ({3'b000, dh[3:0]} * 7'd10) + {3'b000, dl[3:0]};
    return r;
  endfunction

  // HH:MM -> minutes after midnight
  function automatic hhmm_t hh_mm(input logic [7:0] h1, input logic [7:0] h0,
                                  input logic [7:0] sep,
                                  input logic [7:0] m1, input logic [7:0] m0);
    hhmm_t r;
    dig2_t h;
    dig2_t m;
    h      = dig2(h1, h0);
    m      = dig2(m1, m0);
    r.ok   = (sep == CH_COLON) && h.ok && m.ok &&
             ({1'b0, h.val} <= HOUR_MAX) && ({1'b0, m.val} <= MIN_MAX);
    r.mins = ({4'b0000, h.val} * MIN_PER_H) + {4'b0000, m.val};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsc_if.sv =====
`default_nettype none

interface tsc_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [4:0]  hours;
  logic [5:0]  minutes_out;
  logic [5:0]  seconds_out;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [6:0]  year_offset;
  logic [10:0] feed_first;
  logic [10:0] feed_second;
  logic [10:0] feed_third;
  modport source (output valid, output outcome, output hours, output minutes_out,
                  output seconds_out, output day_of_month, output month_number,
                  output year_offset, output feed_first, output feed_second,
                  output feed_third, input ready);
  modport sink   (input valid, input outcome, input hours, input minutes_out,
                  input seconds_out, input day_of_month, input month_number,
                  input year_offset, input feed_first, input feed_second,
                  input feed_third, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/time_and_schedule_command_parser.sv =====
// Result: the last byte moves a payload into the judge stage, then into the result register once it is free.
// Throughput: one byte per cycle, one-byte payloads included; the judge stage and
//   the result register each hold one payload, and bytes stall only when both are full.
// Reset: byte count and all valid flags clear, schedule returns to 14:00, 19:00, 23:00.
//   The byte store is not cleared; only bytes of the current payload are read.
`default_nettype none

module time_and_schedule_command_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  tsc_cmd_if.sink        cmd_i,
  tsc_res_if.source      res_o
);
  import tsc_pkg::*;

  // Byte store, written in arrival order up to STORE_BYTES. Payload storage,
  // so no reset.
  logic [7:0]  store_q [STORE_BYTES];
  logic [7:0]  cnt_q, cnt_d;

  // Judge stage: a complete payload waits here while its result is formed.
  logic        jv_q, jv_d;
  logic [7:0]  len_q, len_d;

  logic        res_valid_q, res_valid_d;
  res_t        res_q;
  res_t        res_c;
  sched_upd_t  upd_c;
  sched_t      sched_q;

  logic        cmd_acc;
  logic        jmove;
  logic [7:0]  cnt_inc;

  // Judge empties when the result register is free or being drained.
  assign jmove       = jv_q && (!res_valid_q || res_o.ready);
  // The store must hold while a judged payload is stuck behind a full output.
  assign cmd_i.ready = !jv_q || jmove;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // Saturating count of bytes including the one being taken.
  assign cnt_inc = (cnt_q == CNT_MAX) ? CNT_MAX : (cnt_q + 8'd1);

  always_comb begin
    cnt_d = cnt_q;
    jv_d  = jmove ? 1'b0 : jv_q;
    len_d = len_q;
    if (cmd_acc) begin
      if (cmd_i.last_byte) begin
        cnt_d = '0;
        jv_d  = 1'b1;
        len_d = cnt_inc;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (jmove) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc && (cnt_q < 8'(STORE_BYTES))) begin
      store_q[cnt_q[STORE_AW-1:0]] <= cmd_i.data_byte;
    end
    len_q <= len_d;
    if (jmove) begin
      res_q <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      jv_q        <= 1'b0;
      res_valid_q <= 1'b0;
      sched_q[0]  <= FEED0_RST;
      sched_q[1]  <= FEED1_RST;
      sched_q[2]  <= FEED2_RST;
    end else begin
      cnt_q       <= cnt_d;
      jv_q        <= jv_d;
      res_valid_q <= res_valid_d;
      // schedule takes the new times in step with its result
      if (jmove && upd_c.wr) begin
        sched_q <= upd_c.times;
      end
    end
  end

  tsc_judge u_judge (
    .store_i (store_q),
    .len_i   (len_q),
    .sched_i (sched_q),
    .res_o   (res_c),
    .upd_o   (upd_c)
  );

  assign res_o.valid        = res_valid_q;
  assign res_o.outcome      = res_q.outcome;
  assign res_o.hours        = res_q.hours;
  assign res_o.minutes_out  = res_q.minutes_out;
  assign res_o.seconds_out  = res_q.seconds_out;
  assign res_o.day_of_month = res_q.day_of_month;
  assign res_o.month_number = res_q.month_number;
  assign res_o.year_offset  = res_q.year_offset;
  assign res_o.feed_first   = res_q.feed[0];
  assign res_o.feed_second  = res_q.feed[1];
  assign res_o.feed_third   = res_q.feed[2];

`ifndef SYNTHESIS
  // A full judge stage behind a stalled output must block new bytes.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jv_q && res_valid_q && !res_o.ready |-> !cmd_i.ready)
    else $error("byte taken while judge stage blocked");

  // The last byte of a payload restarts the count.
  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && cmd_i.last_byte |=> cnt_q == '0)
    else $error("byte count not cleared after last byte");

  // Stored feed times are always strictly rising.
  a_sched_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sched_q[0] < sched_q[1]) && (sched_q[1] < sched_q[2]))
    else $error("feed schedule out of order");

  // The schedule only moves together with an accepted schedule result.
  a_sched_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sched_q) |-> res_valid_q && (res_q.outcome == OC_SCHED_OK))
    else $error("schedule changed without an accepted schedule command");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tsc_judge.sv =====
`default_nettype none

// Judges one complete payload held in the byte store.
module tsc_judge (
  input  logic [7:0]          store_i [tsc_pkg::STORE_BYTES],
  input  logic [7:0]          len_i,
  input  tsc_pkg::sched_t     sched_i,
  output tsc_pkg::res_t       res_o,
  output tsc_pkg::sched_upd_t upd_o
);
  import tsc_pkg::*;

  logic        is_sched;
  logic        tp;
  logic [7:0]  elen;
  logic [7:0]  t [19];
  hhmm_t       fa, fb, fc;
  logic        sched_ok;

  logic        f3_ok, f7_ok, f8_ok, fl_ok;
  logic [15:0] yr16;
  dig2_t       p8h, p8m, p8s;
  dig2_t       lyh, lyl, lmo, ldy, lh, lm, ls;
  logic        lsep_ok;

  always_comb begin
    is_sched = (len_i >= LEN_PREFIX) && (store_i[0] == CH_F) && (store_i[1] == CH_COLON);
    tp       = (len_i >= LEN_PREFIX) && (store_i[0] == CH_T) && (store_i[1] == CH_COLON);
    elen     = tp ? (len_i - LEN_PREFIX) : len_i;
    for (int k = 0; k < 19; k++) begin
      t[k] = tp ? store_i[k + 2] : store_i[k];
    end
  end

  // schedule: HH:MM,HH:MM,HH:MM after "F:"
  always_comb begin
    fa = hh_mm(store_i[2], store_i[3], store_i[4], store_i[5], store_i[6]);
    fb = hh_mm(store_i[8], store_i[9], store_i[10], store_i[11], store_i[12]);
    fc = hh_mm(store_i[14], store_i[15], store_i[16], store_i[17], store_i[18]);
    sched_ok = (len_i == LEN_SCHED) && (store_i[7] == CH_COMMA) &&
               (store_i[13] == CH_COMMA) && fa.ok && fb.ok && fc.ok &&
               (fa.mins < fb.mins) && (fb.mins < fc.mins);
  end

  // time forms
  always_comb begin
    f3_ok = (t[0] <= HOUR_MAX) && (t[1] <= MIN_MAX) && (t[2] <= MIN_MAX);

    yr16  = {t[0], t[1]};
    f7_ok = (yr16 >= YEAR_LO) && (yr16 <= YEAR_HI) &&
            (t[2] != 8'd0) && (t[2] <= MON_MAX) &&
            (t[3] != 8'd0) && (t[3] <= DAY_MAX) &&
            (t[4] <= HOUR_MAX) && (t[5] <= MIN_MAX) && (t[6] <= MIN_MAX);

    p8h   = dig2(t[0], t[1]);
    p8m   = dig2(t[3], t[4]);
    p8s   = dig2(t[6], t[7]);
    f8_ok = (t[2] == CH_COLON) && (t[5] == CH_COLON) && p8h.ok && p8m.ok && p8s.ok &&
            ({1'b0, p8h.val} <= HOUR_MAX) && ({1'b0, p8m.val} <= MIN_MAX) &&
            ({1'b0, p8s.val} <= MIN_MAX);

    lyh     = dig2(t[0], t[1]);
    lyl     = dig2(t[2], t[3]);
    lmo     = dig2(t[5], t[6]);
    ldy     = dig2(t[8], t[9]);
    lh      = dig2(t[11], t[12]);
    lm      = dig2(t[14], t[15]);
    ls      = dig2(t[17], t[18]);
    lsep_ok = (t[4] == CH_DASH) && (t[7] == CH_DASH) &&
              ((t[10] == CH_SPACE) || (t[10] == CH_T)) &&
              (t[13] == CH_COLON) && (t[16] == CH_COLON);
    // year 2000..2099 is exactly a leading "20"
    fl_ok   = lsep_ok && lyh.ok && lyl.ok && (lyh.val == CENTURY) &&
              lmo.ok && (lmo.val != 7'd0) && ({1'b0, lmo.val} <= MON_MAX) &&
              ldy.ok && (ldy.val != 7'd0) && ({1'b0, ldy.val} <= DAY_MAX) &&
              lh.ok && ({1'b0, lh.val} <= HOUR_MAX) &&
              lm.ok && ({1'b0, lm.val} <= MIN_MAX) &&
              ls.ok && ({1'b0, ls.val} <= MIN_MAX);
  end

  always_comb begin
    upd_o.wr       = is_sched && sched_ok;
    upd_o.times[0] = fa.mins;
    upd_o.times[1] = fb.mins;
    upd_o.times[2] = fc.mins;

    res_o              = '0;
    res_o.outcome      = OC_TIME_BAD;
    res_o.feed         = upd_o.wr ? upd_o.times : sched_i;

    if (is_sched) begin
      res_o.outcome = sched_ok ? OC_SCHED_OK : OC_SCHED_BAD;
    end else if ((elen == LEN_BIN_S) && f3_ok) begin
      res_o.outcome      = OC_TIME_OK;
      res_o.hours        = t[0][4:0];
      res_o.minutes_out  = t[1][5:0];
      res_o.seconds_out  = t[2][5:0];
      res_o.day_of_month = 5'd1;
      res_o.month_number = 4'd1;
      res_o.year_offset  = SHORT_YEAR;
    end else if ((elen == LEN_BIN_L) && f7_ok) begin
      res_o.outcome      = OC_TIME_OK;
      res_o.hours        = t[4][4:0];
      res_o.minutes_out  = t[5][5:0];
      res_o.seconds_out  = t[6][5:0];
      res_o.day_of_month = t[3][4:0];
      res_o.month_number = t[2][3:0];
      res_o.year_offset  = 7'(yr16 - YEAR_LO);
    end else if ((elen == LEN_TXT_S) && f8_ok) begin
      res_o.outcome      = OC_TIME_OK;
      res_o.hours        = p8h.val[4:0];
      res_o.minutes_out  = p8m.val[5:0];
      res_o.seconds_out  = p8s.val[5:0];
      res_o.day_of_month = 5'd1;
      res_o.month_number = 4'd1;
      res_o.year_offset  = SHORT_YEAR;
    end else if ((elen >= LEN_TXT_L) && fl_ok) begin
      res_o.outcome      = OC_TIME_OK;
      res_o.hours        = lh.val[4:0];
      res_o.minutes_out  = lm.val[5:0];
      res_o.seconds_out  = ls.val[5:0];
      res_o.day_of_month = ldy.val[4:0];
      res_o.month_number = lmo.val[3:0];
      res_o.year_offset  = lyl.val;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_time_and_schedule_command_parser.sv =====
`timescale 1ns / 100ps

module tb_time_and_schedule_command_parser;
  import tsc_pkg::*;

  // random part: bytes to send, spread over the four idling phases
  localparam int RND_BYTES = 330;
  // marker for an unreadable digit pair or field
  localparam int NO_VALUE  = 255;

  // one directed payload: leading bytes, total length (random filler past
  // the lead), and a typed-in result where one is easy to state
  typedef struct packed {
    logic [255:0] lead;
    logic [8:0]   total;
    logic         known;
    res_t         want;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tsc_cmd_if cmd_bus ();
  tsc_res_if res_bus ();

  time_and_schedule_command_parser uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: byte store, saturating count, feed schedule
  // ---------------------------------------------------------------------
  logic [7:0]  held_bytes [STORE_BYTES];
  logic [7:0]  held_count;
  logic [10:0] feed_now [3];

  res_t        due_results [$];  // results still owed by the block, oldest first
  res_t        next_due;
  int          miss_count;

  int          idle_pct;         // sender idles in this many cycles of a hundred
  int          stall_pct;        // receiver stalls in this many

  logic [7:0]  pay_q [$];        // payload being built or sent
  cmd_row_t    directed_rows [32];
  int          row_total;

  // store entries past the end read as zero
  function automatic int stored(input int i);
    if (i < STORE_BYTES) return int'(held_bytes[i]);
    return 0;
  endfunction

  // two ASCII digits at i, i+1 -> 0..99, else NO_VALUE
  function automatic int dec_pair(input int i);
    int a;
    int b;
    a = stored(i);
    b = stored(i + 1);
    if (a < CH_ZERO || a > CH_NINE || b < CH_ZERO || b > CH_NINE) return NO_VALUE;
    return (a - CH_ZERO) * 10 + (b - CH_ZERO);
  endfunction

  // HH:MM at i -> minutes after midnight, else -1
  function automatic int clock_mins(input int i);
    int h;
    int m;
    h = dec_pair(i);
    m = dec_pair(i + 3);
    if (stored(i + 2) != CH_COLON || h > HOUR_MAX || m > MIN_MAX) return -1;
    return h * 60 + m;
  endfunction

  // Takes one byte into the predictor; on the last byte judges the payload.
  task automatic parse_byte(input logic [7:0] b, input bit fin,
                            output bit got, output res_t r);
    int len;
    int o;
    int h;
    int mi;
    int s;
    int d;
    int mo;
    int y;
    int yr;
    int t1;
    int t2;
    int t3;
    int sep;
    got = 1'b0;
    r   = '0;
    if (held_count < STORE_BYTES) held_bytes[held_count] = b;
    if (held_count != CNT_MAX) held_count = held_count + 8'd1;
    if (fin) begin
      got        = 1'b1;
      len        = int'(held_count);
      held_count = '0;
      if (len >= 2 && stored(0) == CH_F && stored(1) == CH_COLON) begin
        // schedule command: exact length, commas, three rising HH:MM
        r.outcome = OC_SCHED_BAD;
        if (len == LEN_SCHED && stored(7) == CH_COMMA && stored(13) == CH_COMMA) begin
          t1 = clock_mins(2);
          t2 = clock_mins(8);
          t3 = clock_mins(14);
          if (t1 >= 0 && t1 < t2 && t2 < t3) begin
            feed_now[0] = 11'(t1);
            feed_now[1] = 11'(t2);
            feed_now[2] = 11'(t3);
            r.outcome   = OC_SCHED_OK;
          end
        end
      end else begin
        h  = NO_VALUE;
        mi = NO_VALUE;
        s  = NO_VALUE;
        d  = 1;
        mo = 1;
        y  = SHORT_YEAR;
        o  = 0;
        if (len >= 2 && stored(0) == CH_T && stored(1) == CH_COLON) begin
          o   = 2;
          len = len - 2;
        end
        if (len == LEN_BIN_S) begin
          h  = stored(o);
          mi = stored(o + 1);
          s  = stored(o + 2);
        end else if (len == LEN_BIN_L) begin
          yr = stored(o) * 256 + stored(o + 1);
          mo = stored(o + 2);
          d  = stored(o + 3);
          h  = stored(o + 4);
          mi = stored(o + 5);
          s  = stored(o + 6);
          if (yr < YEAR_LO || yr > YEAR_HI || mo < 1 || mo > MON_MAX || d < 1 || d > DAY_MAX)
            h = NO_VALUE;
          else
            y = yr - YEAR_LO;
        end else if (len == LEN_TXT_S) begin
          if (stored(o + 2) == CH_COLON && stored(o + 5) == CH_COLON) begin
            h  = dec_pair(o);
            mi = dec_pair(o + 3);
            s  = dec_pair(o + 6);
          end
        end else if (len >= LEN_TXT_L) begin
          sep = stored(o + 10);
          if (stored(o + 4) == CH_DASH && stored(o + 7) == CH_DASH &&
              (sep == CH_SPACE || sep == CH_T) &&
              stored(o + 13) == CH_COLON && stored(o + 16) == CH_COLON &&
              dec_pair(o) != NO_VALUE && dec_pair(o + 2) != NO_VALUE) begin
            yr = dec_pair(o) * 100 + dec_pair(o + 2);
            mo = dec_pair(o + 5);
            d  = dec_pair(o + 8);
            h  = dec_pair(o + 11);
            mi = dec_pair(o + 14);
            s  = dec_pair(o + 17);
            if (yr < YEAR_LO || yr > YEAR_HI || mo < 1 || mo > MON_MAX ||
                d < 1 || d > DAY_MAX)
              h = NO_VALUE;
            else
              y = yr - YEAR_LO;
          end
        end
        if (h > HOUR_MAX || mi > MIN_MAX || s > MIN_MAX) begin
          r.outcome = OC_TIME_BAD;
        end else begin
          r.outcome      = OC_TIME_OK;
          r.hours        = 5'(h);
          r.minutes_out  = 6'(mi);
          r.seconds_out  = 6'(s);
          r.day_of_month = 5'(d);
          r.month_number = 4'(mo);
          r.year_offset  = 7'(y);
        end
      end
      // schedule as it stands after this payload
      r.feed[0] = feed_now[0];
      r.feed[1] = feed_now[1];
      r.feed[2] = feed_now[2];
    end
  endtask

  function automatic res_t mk_res(input outcome_e oc, input int h, input int mi, input int s,
                                  input int d, input int mo, input int y,
                                  input int f0, input int f1, input int f2);
    res_t r;
    r.outcome      = oc;
    r.hours        = 5'(h);
    r.minutes_out  = 6'(mi);
    r.seconds_out  = 6'(s);
    r.day_of_month = 5'(d);
    r.month_number = 4'(mo);
    r.year_offset  = 7'(y);
    r.feed[0]      = 11'(f0);
    r.feed[1]      = 11'(f1);
    r.feed[2]      = 11'(f2);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------
  task automatic add_text(input string s, input int total, input bit known, input res_t want);
    cmd_row_t r;
    r = '0;
    for (int i = 0; i < s.len(); i++) r.lead[8*i +: 8] = s[i];
    r.total = 9'((total == 0) ? s.len() : total);
    r.known = known;
    r.want  = want;
    directed_rows[row_total] = r;
    row_total++;
  endtask

  // binary payload, first byte in the top of the used part of v
  task automatic add_bin(input logic [55:0] v, input int n, input bit tpfx,
                         input bit known, input res_t want);
    cmd_row_t r;
    int k;
    r = '0;
    k = 0;
    if (tpfx) begin
      r.lead[7:0]  = CH_T;
      r.lead[15:8] = CH_COLON;
      k = 2;
    end
    for (int i = 0; i < n; i++) r.lead[8*(k+i) +: 8] = v[8*(n-1-i) +: 8];
    r.total = 9'(k + n);
    r.known = known;
    r.want  = want;
    directed_rows[row_total] = r;
    row_total++;
  endtask

  task automatic load_table();
    res_t bad_t;
    res_t bad_s;
    bad_t = mk_res(OC_TIME_BAD, 0, 0, 0, 0, 0, 0, FEED0_RST, FEED1_RST, FEED2_RST);
    row_total = 0;
    // first payload is long enough to write every store entry
    add_text("2026-03-15 12:34:56 ok!", 0, 1'b1,
             mk_res(OC_TIME_OK, 12, 34, 56, 15, 3, 26, FEED0_RST, FEED1_RST, FEED2_RST));
    add_text("2099-12-31T23:59:59", 0, 1'b1,
             mk_res(OC_TIME_OK, 23, 59, 59, 31, 12, 99, FEED0_RST, FEED1_RST, FEED2_RST));
    add_text("T:2050-06-30T01:02:03", 0, 1'b1,
             mk_res(OC_TIME_OK, 1, 2, 3, 30, 6, 50, FEED0_RST, FEED1_RST, FEED2_RST));
    add_text("1999-12-31 23:59:59", 0, 1'b1, bad_t);
    add_text("2026-13-01 00:00:00", 0, 1'b1, bad_t);
    add_text("2026-01-01 24:00:00", 0, 1'b1, bad_t);
    add_text("2026-01-01X00:00:00", 0, 1'b1, bad_t);
    add_text("23:59:59", 0, 1'b1,
             mk_res(OC_TIME_OK, 23, 59, 59, 1, 1, 26, FEED0_RST, FEED1_RST, FEED2_RST));
    add_text("T:00:00:00", 0, 1'b1,
             mk_res(OC_TIME_OK, 0, 0, 0, 1, 1, 26, FEED0_RST, FEED1_RST, FEED2_RST));
    add_text("12:60:00", 0, 1'b1, bad_t);
    // binary forms, range edges
    add_bin(56'h173B3B, 3, 1'b0, 1'b1,
            mk_res(OC_TIME_OK, 23, 59, 59, 1, 1, 26, FEED0_RST, FEED1_RST, FEED2_RST));
    add_bin(56'h000000, 3, 1'b0, 1'b1,
            mk_res(OC_TIME_OK, 0, 0, 0, 1, 1, 26, FEED0_RST, FEED1_RST, FEED2_RST));
    add_bin(56'h180000, 3, 1'b0, 1'b1, bad_t);
    add_bin(56'h07D0_0101_000000, 7, 1'b0, 1'b1,
            mk_res(OC_TIME_OK, 0, 0, 0, 1, 1, 0, FEED0_RST, FEED1_RST, FEED2_RST));
    add_bin(56'h0833_0C1F_173B3B, 7, 1'b0, 1'b1,
            mk_res(OC_TIME_OK, 23, 59, 59, 31, 12, 99, FEED0_RST, FEED1_RST, FEED2_RST));
    add_bin(56'h0834_0101_000000, 7, 1'b1, 1'b1, bad_t);
    add_bin(56'h07EA_0200_0C0000, 7, 1'b0, 1'b1, bad_t);
    add_bin(56'hFFFFFF, 3, 1'b1, 1'b1, bad_t);
    // single byte payload and a length that fits no form
    add_text("F", 0, 1'b1, bad_t);
    add_text("T:12", 0, 1'b1, bad_t);
    // schedule commands: extremes, then rejects that leave it alone
    add_text("F:00:00,11:59,23:59", 0, 1'b1,
             mk_res(OC_SCHED_OK, 0, 0, 0, 0, 0, 0, 0, 719, 1439));
    bad_s = mk_res(OC_SCHED_BAD, 0, 0, 0, 0, 0, 0, 0, 719, 1439);
    add_text("F:10:00,10:00,12:00", 0, 1'b1, bad_s);
    add_text("F:01:00,02:00,03:0", 0, 1'b1, bad_s);
    add_text("F:", 0, 1'b1, bad_s);
    // overlong: count saturates, the text form still reads its first 19 bytes
    add_text("2026-02-03 04:05:06", 300, 1'b0, '0);
    add_text("F:", 256, 1'b1, bad_s);
  endtask

  // ---------------------------------------------------------------------
  // Random payloads
  // ---------------------------------------------------------------------
  // mostly in range, edges often, now and then anywhere up to wide
  function automatic int pick_value(input int lo, input int hi, input int wide);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r == 2) return $urandom_range(0, wide);
    return $urandom_range(lo, hi);
  endfunction

  task automatic push_pair(input int v);
    pay_q.push_back(8'(int'(CH_ZERO) + v / 10));
    pay_q.push_back(8'(int'(CH_ZERO) + v % 10));
  endtask

  task automatic build_payload();
    int    kind;
    int    yr;
    int    n;
    int    t [3];
    int    tmp;
    int    idx;
    int    r;
    string charset;
    charset = "0123456789:-, TF";
    pay_q.delete();
    kind = $urandom_range(0, 99);
    // time forms take a T: prefix a quarter of the time
    if (kind < 63 && $urandom_range(0, 3) == 0) begin
      pay_q.push_back(CH_T);
      pay_q.push_back(CH_COLON);
    end
    if (kind < 15) begin
      pay_q.push_back(8'(pick_value(0, 23, 255)));
      pay_q.push_back(8'(pick_value(0, 59, 255)));
      pay_q.push_back(8'(pick_value(0, 59, 255)));
    end else if (kind < 30) begin
      r  = $urandom_range(0, 15);
      yr = (r == 0) ? $urandom_range(0, 65535) : pick_value(2000, 2099, 2200);
      pay_q.push_back(8'(yr >> 8));
      pay_q.push_back(8'(yr));
      pay_q.push_back(8'(pick_value(1, 12, 255)));
      pay_q.push_back(8'(pick_value(1, 31, 255)));
      pay_q.push_back(8'(pick_value(0, 23, 255)));
      pay_q.push_back(8'(pick_value(0, 59, 255)));
      pay_q.push_back(8'(pick_value(0, 59, 255)));
    end else if (kind < 45) begin
      push_pair(pick_value(0, 23, 99));
      pay_q.push_back(CH_COLON);
      push_pair(pick_value(0, 59, 99));
      pay_q.push_back(CH_COLON);
      push_pair(pick_value(0, 59, 99));
    end else if (kind < 63) begin
      yr = pick_value(2000, 2099, 9999);
      push_pair(yr / 100);
      push_pair(yr % 100);
      pay_q.push_back(CH_DASH);
      push_pair(pick_value(1, 12, 99));
      pay_q.push_back(CH_DASH);
      push_pair(pick_value(1, 31, 99));
      r = $urandom_range(0, 4);
      if (r < 2)      pay_q.push_back(CH_SPACE);
      else if (r < 4) pay_q.push_back(CH_T);
      else            pay_q.push_back(8'($urandom));
      push_pair(pick_value(0, 23, 99));
      pay_q.push_back(CH_COLON);
      push_pair(pick_value(0, 59, 99));
      pay_q.push_back(CH_COLON);
      push_pair(pick_value(0, 59, 99));
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) pay_q.push_back(8'($urandom));
    end else if (kind < 81) begin
      // schedule: mostly sorted, so equal neighbours and rising ones both occur
      for (int j = 0; j < 3; j++) t[j] = pick_value(0, 1439, 1439);
      if ($urandom_range(0, 4) != 0) begin
        if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
        if (t[1] > t[2]) begin tmp = t[1]; t[1] = t[2]; t[2] = tmp; end
        if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
      end
      pay_q.push_back(CH_F);
      pay_q.push_back(CH_COLON);
      for (int j = 0; j < 3; j++) begin
        if (j > 0) pay_q.push_back(CH_COMMA);
        push_pair(($urandom_range(0, 11) == 0) ? $urandom_range(24, 99) : t[j] / 60);
        pay_q.push_back(CH_COLON);
        push_pair(t[j] % 60);
      end
    end else begin
      // noise: raw bytes or parser characters, sometimes behind a prefix
      n = $urandom_range(1, 24);
      r = $urandom_range(0, 5);
      if (r == 0 && n > 1) begin
        pay_q.push_back(CH_F);
        pay_q.push_back(CH_COLON);
      end else if (r == 1 && n > 1) begin
        pay_q.push_back(CH_T);
        pay_q.push_back(CH_COLON);
      end
      while (pay_q.size() < n) begin
        if ($urandom_range(0, 1) == 0) pay_q.push_back(8'($urandom));
        else pay_q.push_back(8'(charset[$urandom_range(0, 15)]));
      end
    end
    // broken sequences: one byte spoilt, or the length off by one
    if (kind < 81 && $urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, pay_q.size() - 1);
      pay_q[idx] = 8'($urandom);
    end
    if (kind < 81 && $urandom_range(0, 15) == 0) begin
      if (pay_q.size() > 1 && $urandom_range(0, 1) == 0) void'(pay_q.pop_back());
      else pay_q.push_back(8'($urandom));
    end
    // rare overlong payload, lengths around the count's saturation point
    if ($urandom_range(0, 99) == 0) begin
      n = $urandom_range(250, 300);
      while (pay_q.size() < n) pay_q.push_back(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Command side: one item per byte, NBA drive at the rising edge
  // ---------------------------------------------------------------------
  task automatic feed_byte(input logic [7:0] b, input bit fin, input bit known,
                           input res_t want);
    bit   got;
    res_t guess;
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.data_byte <= b;
    cmd_bus.last_byte <= fin;
    @(posedge clk);
    // ready read just after the edge is the value the edge saw
    while (!cmd_bus.ready) @(posedge clk);
    parse_byte(b, fin, got, guess);
    if (got) due_results.push_back(known ? want : guess);
  endtask

  task automatic send_payload(input bit known, input res_t want);
    for (int i = 0; i < pay_q.size(); i++)
      feed_byte(pay_q[i], (i == pay_q.size() - 1), known, want);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    miss_count++;
  endtask

  task automatic compare_field(input string name, input logic [10:0] got,
                               input logic [10:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        next_due = due_results.pop_front();
        compare_field("outcome",      11'(res_bus.outcome),      11'(next_due.outcome));
        compare_field("hours",        11'(res_bus.hours),        11'(next_due.hours));
        compare_field("minutes_out",  11'(res_bus.minutes_out),  11'(next_due.minutes_out));
        compare_field("seconds_out",  11'(res_bus.seconds_out),  11'(next_due.seconds_out));
        compare_field("day_of_month", 11'(res_bus.day_of_month),
                      11'(next_due.day_of_month));
        compare_field("month_number", 11'(res_bus.month_number),
                      11'(next_due.month_number));
        compare_field("year_offset",  11'(res_bus.year_offset),  11'(next_due.year_offset));
        compare_field("feed_first",   res_bus.feed_first,   next_due.feed[0]);
        compare_field("feed_second",  res_bus.feed_second,  next_due.feed[1]);
        compare_field("feed_third",   res_bus.feed_third,   next_due.feed[2]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    cmd_row_t row;
    int       rnd_sent;
    rst_n             <= 1'b0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.data_byte <= '0;
    cmd_bus.last_byte <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    miss_count = 0;
    rnd_sent   = 0;
    held_count = '0;
    for (int i = 0; i < STORE_BYTES; i++) held_bytes[i] = '0;
    feed_now[0] = FEED0_RST;
    feed_now[1] = FEED1_RST;
    feed_now[2] = FEED2_RST;
    load_table();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, no idling on either side
    for (int j = 0; j < row_total; j++) begin
      row = directed_rows[j];
      pay_q.delete();
      for (int i = 0; i < row.total; i++)
        pay_q.push_back((i < 32) ? row.lead[8*i +: 8] : 8'($urandom));
      send_payload(row.known, row.want);
    end

    // random payloads: free flow, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      while (rnd_sent < RND_BYTES * (ph + 1) / 4) begin
        build_payload();
        rnd_sent += pay_q.size();
        send_payload(1'b0, '0);
      end
    end
    cmd_bus.valid <= 1'b0;

    // drain, then give anything stray time to show
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (miss_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #1000000;
    $display("ERROR: run timed out");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
